// ===== rtl/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// sce_pkg: shared types and constants for the smoothed channel energy block
// Field widths, request and response payload types, the state memory entry,
// register indexes and reset values.
// ----------------------------------------------------------------------------
package sce_pkg;

   // Field widths
   localparam int ChW     = 3;
   localparam int SampleW = 16;
   localparam int AccW    = 43;
   localparam int AvgW    = 59;
   localparam int CountW  = 4;
   localparam int FactorW = 16;
   localparam int MagW    = SampleW + 1;
   localparam int SqW     = 2 * MagW;

   // Default channel capacity
   localparam int MaxChannelsDef = 8;

   // Scaler split: the difference is multiplied in two slices
   localparam int LoW  = 30;
   localparam int HiW  = AvgW - LoW;
   localparam int MulW = LoW + FactorW;
   localparam int SumW = HiW + FactorW + LoW + 1;

   // Configuration port
   localparam int CsrIndexW = 1;
   localparam int CsrDataW  = 16;
   localparam logic [CsrIndexW-1:0] CsrChannelCount   = 1'b0;
   localparam logic [CsrIndexW-1:0] CsrSmoothingFactor = 1'b1;

   localparam logic [CountW-1:0]  ChannelCountReset = 4'd2;
   localparam logic [FactorW-1:0] FactorReset       = 16'd655;

   typedef struct packed {
      logic [ChW-1:0]            channel;
      logic signed [SampleW-1:0] sample;
      logic signed [SampleW-1:0] dc_offset;
      logic                      last_in_frame;
   } req_type;

   typedef struct packed {
      logic [ChW-1:0]  out_channel;
      logic [AccW-1:0] frame_energy;
      logic [AvgW-1:0] average_energy;
   } rsp_type;

   typedef struct packed {
      logic [AccW-1:0] acc;
      logic [AvgW-1:0] avg;
   } entry_type;

endpackage

// ===== rtl/sce_state_mem.sv =====
// ----------------------------------------------------------------------------
// sce_state_mem: per-channel state memory
// One write and one read port, read data registered. Per-entry valid bits
// make entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module sce_state_mem #(
   parameter int Depth = sce_pkg::MaxChannelsDef,
   parameter int AddrW = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [AddrW-1:0]      rd_addr,
   output sce_pkg::entry_type    rd_data,
   input  logic                  wr_en,
   input  logic [AddrW-1:0]      wr_addr,
   input  sce_pkg::entry_type    wr_data
);

   sce_pkg::entry_type mem [Depth];
   sce_pkg::entry_type data_ff;
   logic [Depth-1:0]   valid_ff;
   logic               rd_valid_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   // Track written entries
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? data_ff : '0;

endmodule

// ===== rtl/sce_scaler.sv =====
// ----------------------------------------------------------------------------
// sce_scaler: multi-cycle Q16 scaling unit
// Computes (d * f) >> 16 for a 59-bit d and 16-bit f with one shared
// 30x16 multiplier, low slice first and then high slice, and a final add.
// ----------------------------------------------------------------------------
module sce_scaler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sce_pkg::AvgW-1:0]    diff,
   input  logic [sce_pkg::FactorW-1:0] factor,
   output logic                        done,
   output logic [sce_pkg::AvgW-1:0]    result
);

   typedef enum logic [3:0] {
      SC_IDLE = 4'b0001,
      SC_LO   = 4'b0010,
      SC_HI   = 4'b0100,
      SC_SUM  = 4'b1000
   } sc_state_type;

   sc_state_type                   state_ff, state_in;
   logic [sce_pkg::AvgW-1:0]       diff_ff;
   logic [sce_pkg::FactorW-1:0]    factor_ff;
   logic [sce_pkg::MulW-1:0]       p_lo_ff;
   logic [sce_pkg::MulW-2:0]       p_hi_ff;
   logic [sce_pkg::AvgW-1:0]       result_ff;
   logic                           done_ff;
   logic [sce_pkg::LoW-1:0]        mul_a;
   logic [sce_pkg::MulW-1:0]       mul_p;
   logic [sce_pkg::SumW-1:0]       sum;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SC_IDLE: if (start) state_in = SC_LO;
         SC_LO:   state_in = SC_HI;
         SC_HI:   state_in = SC_SUM;
         SC_SUM:  state_in = SC_IDLE;
         default: state_in = SC_IDLE;
      endcase
   end

   // Shared multiplier: low slice first, then high slice
   assign mul_a = (state_ff == SC_LO) ? diff_ff[sce_pkg::LoW-1:0]
                                      : sce_pkg::LoW'(diff_ff[sce_pkg::AvgW-1:sce_pkg::LoW]);
   assign mul_p = mul_a * factor_ff;

   // Recombine slices and drop the Q16 fraction
   assign sum = sce_pkg::SumW'({p_hi_ff, {sce_pkg::LoW{1'b0}}}) + sce_pkg::SumW'(p_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == SC_SUM);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == SC_IDLE && start) begin
         diff_ff   <= diff;
         factor_ff <= factor;
      end
      if (state_ff == SC_LO) begin
         p_lo_ff <= mul_p;
      end
      if (state_ff == SC_HI) begin
         p_hi_ff <= mul_p[sce_pkg::MulW-2:0];
      end
      if (state_ff == SC_SUM) begin
         result_ff <= sum[sce_pkg::FactorW +: sce_pkg::AvgW];
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== rtl/smoothed_channel_energy_top.sv =====
// ----------------------------------------------------------------------------
// smoothed_channel_energy_top: per-channel frame energy with EMA smoothing
// Accumulates squared DC-removed samples per channel and folds each finished
// frame into a Q16 running average.
// ----------------------------------------------------------------------------
// A sample that does not end its frame is accepted in ST_IDLE, which reads
// the channel's entry from the state memory; ST_ACC then adds its square,
// writes the entry back and returns to ST_IDLE. A sample that ends a frame
// goes on through ST_DIFF for the compare, ST_SCALE while the shared 30x16
// multiplier scales the 59-bit difference in two slices, and ST_UPD for the
// final update. Requests for a channel at or above the channel count or
// MAX_CHANNELS are taken and dropped. A result waiting in the output register
// does not hold off new requests; only a second frame end waits for it to
// drain. State entries read as zero after reset until first written.
module smoothed_channel_energy_top #(
   parameter int MAX_CHANNELS = sce_pkg::MaxChannelsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sce_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sce_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [sce_pkg::CsrIndexW-1:0] csr_index,
   input  logic [sce_pkg::CsrDataW-1:0]  csr_wdata
);

   localparam int AddrW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ChWide = sce_pkg::ChW + AddrW;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ACC   = 5'b00010,
      ST_DIFF  = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_UPD   = 5'b10000
   } st_type;

   st_type                          state_ff, state_in;
   logic [sce_pkg::CountW-1:0]      count_ff;
   logic [sce_pkg::FactorW-1:0]     factor_ff;
   logic [AddrW-1:0]                addr_ff;
   logic [sce_pkg::ChW-1:0]         ch_ff;
   logic                            last_ff;
   logic [sce_pkg::SqW-1:0]         sq_ff;
   logic [sce_pkg::AccW-1:0]        acc_ff;
   logic [sce_pkg::AvgW-1:0]        avg_ff;
   logic                            up_ff;
   logic                            rsp_valid_ff;
   sce_pkg::rsp_type                rsp_data_ff;

   logic                            req_fire;
   logic [ChWide-1:0]               ch_wide;
   logic                            active;
   logic [AddrW-1:0]                addr_in;
   logic signed [sce_pkg::MagW-1:0] diff_s;
   logic [sce_pkg::MagW-1:0]        mag;
   logic [sce_pkg::SqW-1:0]         sq_in;
   sce_pkg::entry_type              rd_entry;
   sce_pkg::entry_type              wr_entry;
   logic                            wr_en;
   logic [sce_pkg::AccW:0]          acc_sum;
   logic [sce_pkg::AccW-1:0]        acc_in;
   logic [sce_pkg::AvgW-1:0]        target;
   logic                            up_in;
   logic [sce_pkg::AvgW-1:0]        sc_diff;
   logic                            sc_done;
   logic [sce_pkg::AvgW-1:0]        sc_result;
   logic [sce_pkg::AvgW-1:0]        avg_in;
   logic                            out_free;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= sce_pkg::ChannelCountReset;
         factor_ff <= sce_pkg::FactorReset;
      end else if (csr_we) begin
         unique case (csr_index)
            sce_pkg::CsrChannelCount:    count_ff  <= csr_wdata[sce_pkg::CountW-1:0];
            sce_pkg::CsrSmoothingFactor: factor_ff <= csr_wdata[sce_pkg::FactorW-1:0];
            default: ;
         endcase
      end
   end

   // Request decode: channel range check and sample square
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign ch_wide   = {{AddrW{1'b0}}, req_data.channel};
   assign active    = ({1'b0, req_data.channel} < count_ff)
                      && (ch_wide < ChWide'(MAX_CHANNELS));
   assign addr_in   = ch_wide[AddrW-1:0];
   assign diff_s    = sce_pkg::MagW'(req_data.sample) - sce_pkg::MagW'(req_data.dc_offset);
   assign mag       = diff_s[sce_pkg::MagW-1] ? sce_pkg::MagW'(-diff_s)
                                              : sce_pkg::MagW'(diff_s);
   assign sq_in     = mag * mag;

   // Saturating accumulate
   assign acc_sum = {1'b0, rd_entry.acc} + (sce_pkg::AccW + 1)'(sq_ff);
   assign acc_in  = acc_sum[sce_pkg::AccW] ? '1 : acc_sum[sce_pkg::AccW-1:0];

   // Compare frame energy against the average, form the magnitude
   assign target  = {acc_ff, {sce_pkg::FactorW{1'b0}}};
   assign up_in   = (target >= avg_ff);
   assign sc_diff = up_in ? (target - avg_ff) : (avg_ff - target);

   // Apply the scaled step
   assign avg_in   = up_ff ? (avg_ff + sc_result) : (avg_ff - sc_result);
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire && active) state_in = ST_ACC;
         ST_ACC:   state_in = last_ff ? ST_DIFF : ST_IDLE;
         ST_DIFF:  state_in = ST_SCALE;
         ST_SCALE: if (sc_done) state_in = ST_UPD;
         ST_UPD:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Write back: accumulator alone mid-frame, cleared accumulator and new average at frame end
   always_comb begin
      wr_en    = 1'b0;
      wr_entry = '0;
      if (state_ff == ST_ACC && !last_ff) begin
         wr_en        = 1'b1;
         wr_entry.acc = acc_in;
         wr_entry.avg = rd_entry.avg;
      end else if (state_ff == ST_UPD && out_free) begin
         wr_en        = 1'b1;
         wr_entry.acc = '0;
         wr_entry.avg = avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_UPD && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold request fields and intermediate values
   always_ff @(posedge clock) begin
      if (req_fire) begin
         addr_ff <= addr_in;
         ch_ff   <= req_data.channel;
         last_ff <= req_data.last_in_frame;
         sq_ff   <= sq_in;
      end
      if (state_ff == ST_ACC) begin
         acc_ff <= acc_in;
         avg_ff <= rd_entry.avg;
      end
      if (state_ff == ST_DIFF) begin
         up_ff <= up_in;
      end
      if (state_ff == ST_UPD && out_free) begin
         rsp_data_ff.out_channel    <= ch_ff;
         rsp_data_ff.frame_energy   <= acc_ff;
         rsp_data_ff.average_energy <= avg_in;
      end
   end

   sce_state_mem #(
      .Depth (MAX_CHANNELS),
      .AddrW (AddrW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (addr_in),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_entry)
   );

   sce_scaler u_scaler (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == ST_DIFF),
      .diff   (sc_diff),
      .factor (factor_ff),
      .done   (sc_done),
      .result (sc_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
